FILE: hdl/pba_pkg.sv
// Shared types and constants of the paged bump allocator.
package pba_pkg;

	localparam logic [20:0] PAGE_LIMIT       = 21'd1048576;
	localparam logic [20:0] PAGE_BYTES_RESET = 21'd4096;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_REWIND  = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_BIG  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// token that walks the row of page cells, one cell per cycle
	typedef struct packed {
		logic        valid;
		op_t         kind;
		logic        found;
		logic [7:0]  page;
		logic [19:0] offset;
	} tok_t;

	// request held steady while its token walks the row
	typedef struct packed {
		logic [20:0] size;
		logic [20:0] limit;
	} req_t;

endpackage

FILE: hdl/pba_cell.sv
// One page cell: holds the page fill and opened flag, claims or passes the token.
module pba_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  pba_pkg::tok_t  tok_in,
	input  pba_pkg::req_t  req,
	input  logic [7:0]     index,
	output pba_pkg::tok_t  tok_out
);
	import pba_pkg::*;

	logic [20:0] fill_q;
	logic        open_q;
	tok_t        tok_q;

	logic [20:0] base;
	logic [21:0] sum;
	logic        fits;
	logic        claim;
	tok_t        tok_nxt;

	// an unopened cell counts as empty; the first one reached is the next page to open
	assign base  = open_q ? fill_q : '0;
	assign sum   = {1'b0, base} + {1'b0, req.size};
	assign fits  = sum <= {1'b0, req.limit};
	assign claim = tok_in.valid && (tok_in.kind == OP_ALLOC) && !tok_in.found && fits;

	always_comb begin
		tok_nxt = tok_in;
		if (claim) begin
			tok_nxt.found  = 1'b1;
			tok_nxt.page   = index;
			tok_nxt.offset = base[19:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			open_q <= 1'b0;
			tok_q  <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (claim) begin
				fill_q <= sum[20:0];
				open_q <= 1'b1;
			end else if (tok_in.valid && tok_in.kind == OP_REWIND) begin
				fill_q <= '0;
			end else if (tok_in.valid && tok_in.kind == OP_RELEASE) begin
				fill_q <= '0;
				open_q <= 1'b0;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: hdl/paged_bump_allocator.sv
// Paged bump allocator: page cell row, tag statistics and control.
//
// Input channel (in_valid/in_stall): operation, request_size, request_tag.
// Output channel (out_valid/out_stall): status, page_number, page_offset,
// total_bytes, tag_allocations, tag_bytes; one transaction out per one in.
// Config channel (cfg_valid/cfg_ready): page_bytes, always ready; write it
// only while no request is in flight.
// Each request sends a token down a row of PAGE_COUNT page cells, one cell
// a cycle, and the first cell whose fill still has room takes it. The end
// token is captured in S_SCAN and the result is loaded in S_UPD; in_stall
// is high from acceptance until then, so no request is taken while one is
// in flight. The row length sets how long each request keeps the block busy.
// A finished result sits in the output register; the next request may be
// taken while it waits. If a second result is ready while the first is still
// stalled, the block holds it until the output register frees.
// Reset empties all pages, clears the statistics and sets page_bytes to 4096.
module paged_bump_allocator #(
	parameter int PAGE_COUNT = 256,
	parameter int TAG_COUNT  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [20:0] request_size,
	input  logic [7:0]  request_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  page_number,
	output logic [19:0] page_offset,
	output logic [47:0] total_bytes,
	output logic [31:0] tag_allocations,
	output logic [47:0] tag_bytes,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [20:0] page_bytes
);
	import pba_pkg::*;

	localparam int TAG_W = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} state_t;

	state_t              state_q;
	logic [20:0]         page_bytes_q;
	req_t                req_q;
	op_t                 op_q;
	status_t             status_q;
	logic                tag_ok_q;
	logic [TAG_W-1:0]    tag_idx_q;
	tok_t                inj_q;
	tok_t                end_q;
	logic [47:0]         total_q;
	logic [TAG_COUNT-1:0] tag_vld_q;
	logic [31:0]         cnt_mem [TAG_COUNT];
	logic [47:0]         sz_mem  [TAG_COUNT];
	logic [31:0]         cnt_rd_q;
	logic [47:0]         sz_rd_q;
	logic                vld_rd_q;

	logic                out_valid_q;
	status_t             status_out_q;
	logic [7:0]          page_q;
	logic [19:0]         offset_q;
	logic [47:0]         total_out_q;
	logic [31:0]         tag_cnt_out_q;
	logic [47:0]         tag_sz_out_q;

	tok_t                chain [PAGE_COUNT+1];

	logic                accept;
	logic                upd_fire;
	logic [20:0]         limit;
	logic                tag_ok;
	logic [TAG_W-1:0]    tag_idx;
	op_t                 op_in;
	status_t             st_in;
	op_t                 kind_in;
	logic                succ;
	status_t             st_fin;
	logic [31:0]         cur_cnt;
	logic [47:0]         cur_sz;
	logic [48:0]         total_sum;
	logic [48:0]         sz_sum;
	logic [47:0]         new_total;
	logic [31:0]         new_cnt;
	logic [47:0]         new_sz;

	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign upd_fire  = (state_q == S_UPD) && (!out_valid_q || !out_stall);

	assign limit   = (page_bytes_q > PAGE_LIMIT) ? PAGE_LIMIT : page_bytes_q;
	assign tag_ok  = {1'b0, request_tag} < 9'(TAG_COUNT);
	assign tag_idx = request_tag[TAG_W-1:0];
	assign op_in   = op_t'(operation);

	always_comb begin
		st_in   = ST_OK;
		kind_in = op_in;
		if (op_in == OP_ALLOC) begin
			if (request_size == '0) begin
				st_in   = ST_ZERO;
				kind_in = OP_NONE;
			end else if (request_size > limit) begin
				st_in   = ST_BIG;
				kind_in = OP_NONE;
			end
		end
	end

	// page cell row
	assign chain[0] = inj_q;
	for (genvar i = 0; i < PAGE_COUNT; i++) begin : g_cell
		pba_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[i]),
			.req     (req_q),
			.index   (8'(i)),
			.tok_out (chain[i+1])
		);
	end

	// statistics arithmetic, saturating
	assign succ      = (op_q == OP_ALLOC) && (status_q == ST_OK) && end_q.found;
	assign st_fin    = ((op_q == OP_ALLOC) && (status_q == ST_OK) && !end_q.found)
	                   ? ST_FULL : status_q;
	assign cur_cnt   = vld_rd_q ? cnt_rd_q : '0;
	assign cur_sz    = vld_rd_q ? sz_rd_q  : '0;
	assign total_sum = {1'b0, total_q} + 49'(req_q.size);
	assign sz_sum    = {1'b0, cur_sz} + 49'(req_q.size);

	always_comb begin
		new_total = total_q;
		new_cnt   = cur_cnt;
		new_sz    = cur_sz;
		if (succ) begin
			new_total = total_sum[48] ? '1 : total_sum[47:0];
			new_cnt   = (cur_cnt == '1) ? cur_cnt : cur_cnt + 32'd1;
			new_sz    = sz_sum[48] ? '1 : sz_sum[47:0];
		end
		if (op_q == OP_RELEASE) begin
			new_total = '0;
			new_cnt   = '0;
			new_sz    = '0;
		end
	end

	// per-tag statistics memories
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_rd_q <= cnt_mem[tag_idx];
			sz_rd_q  <= sz_mem[tag_idx];
		end
		if (upd_fire && succ && tag_ok_q) begin
			cnt_mem[tag_idx_q] <= new_cnt;
			sz_mem[tag_idx_q]  <= new_sz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q <= PAGE_BYTES_RESET;
			total_q      <= '0;
			tag_vld_q    <= '0;
			vld_rd_q     <= 1'b0;
			inj_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				page_bytes_q <= page_bytes;
			inj_q.valid <= accept;
			if (accept) begin
				inj_q.kind   <= kind_in;
				inj_q.found  <= 1'b0;
				inj_q.page   <= '0;
				inj_q.offset <= '0;
				vld_rd_q     <= tag_vld_q[tag_idx];
			end
			if (upd_fire) begin
				total_q <= new_total;
				if (op_q == OP_RELEASE)
					tag_vld_q <= '0;
				else if (succ && tag_ok_q)
					tag_vld_q[tag_idx_q] <= 1'b1;
			end
		end
	end

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			req_q         <= '0;
			op_q          <= OP_ALLOC;
			status_q      <= ST_OK;
			tag_ok_q      <= 1'b0;
			tag_idx_q     <= '0;
			end_q         <= '0;
			status_out_q  <= ST_OK;
			page_q        <= '0;
			offset_q      <= '0;
			total_out_q   <= '0;
			tag_cnt_out_q <= '0;
			tag_sz_out_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && !upd_fire)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q.size  <= request_size;
						req_q.limit <= limit;
						op_q        <= op_in;
						status_q    <= st_in;
						tag_ok_q    <= tag_ok;
						tag_idx_q   <= tag_idx;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (chain[PAGE_COUNT].valid) begin
						end_q   <= chain[PAGE_COUNT];
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (upd_fire) begin
						out_valid_q   <= 1'b1;
						status_out_q  <= st_fin;
						page_q        <= succ ? end_q.page : '0;
						offset_q      <= succ ? end_q.offset : '0;
						total_out_q   <= new_total;
						tag_cnt_out_q <= tag_ok_q ? new_cnt : '0;
						tag_sz_out_q  <= tag_ok_q ? new_sz : '0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_out_q;
	assign page_number     = page_q;
	assign page_offset     = offset_q;
	assign total_bytes     = total_out_q;
	assign tag_allocations = tag_cnt_out_q;
	assign tag_bytes       = tag_sz_out_q;

endmodule

FILE: hdl/pba_checker.sv
// Port-level checks for the paged bump allocator, bound to the top level.
module pba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [7:0]  page_number,
	input logic [19:0] page_offset
);
	import pba_pkg::*;

	// a failed allocation carries no placement
	a_fail_no_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (page_number == '0) && (page_offset == '0))
		else $error("failed allocation reports a placement");

	// one request at a time: busy right after a transaction in
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a request is in flight");

	// a fresh result only ever comes out of a busy period
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule

bind paged_bump_allocator pba_checker u_pba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.page_number (page_number),
	.page_offset (page_offset)
);

FILE: tb/tb_paged_bump_allocator.sv
// Self-checking testbench for the paged bump allocator: directed table, then random phases.
module tb_paged_bump_allocator;
	import pba_pkg::*;

	localparam int          PAGES      = 256;
	localparam int          TAGS       = 256;
	localparam int          SETTLE     = 300;
	localparam int          HOLD_OFF   = 2500;
	localparam int unsigned LIMIT      = 1500000;
	localparam int          PHASES     = 8;
	localparam int          RANDOM_PAGE_PHASE = 6;

	typedef struct packed {
		status_t     st;
		logic [7:0]  page;
		logic [19:0] offset;
		logic [47:0] total;
		logic [31:0] count;
		logic [47:0] bytes;
	} outcome_t;

	typedef struct {
		op_t         kind;
		logic [20:0] size;
		logic [7:0]  tag;
		bit          known;
		outcome_t    want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [20:0] request_size;
	logic [7:0]  request_tag;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  page_number;
	logic [19:0] page_offset;
	logic [47:0] total_bytes;
	logic [31:0] tag_allocations;
	logic [47:0] tag_bytes;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [20:0] page_bytes;

	// predictor's copy of the allocator
	logic [20:0] size_setting;
	int          pages_open;
	logic [20:0] fill [PAGES];
	logic [47:0] bytes_total;
	logic [31:0] tag_count [TAGS];
	logic [47:0] tag_sum [TAGS];

	outcome_t    pending_results [$];
	outcome_t    row_want;
	bit          row_known;
	bit          calm;
	bit          hold_off;
	int          outstanding;
	int          items_taken;
	int          results_seen;
	int          errors;
	int unsigned cycles;

	int          phase_items [PHASES] = '{120, 340, 80, 80, 30, 150, 100, 150};
	int          phase_ctrl  [PHASES] = '{8, 0, 8, 8, 8, 5, 8, 2};
	logic [20:0] phase_page  [PHASES] = '{21'd16, 21'd1, 21'd1048576, 21'h1FFFFF,
		21'd0, 21'd4096, 21'd0, 21'd300};

	row_t        directed [17];

	paged_bump_allocator u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.request_size    (request_size),
		.request_tag     (request_tag),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.page_number     (page_number),
		.page_offset     (page_offset),
		.total_bytes     (total_bytes),
		.tag_allocations (tag_allocations),
		.tag_bytes       (tag_bytes),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.page_bytes      (page_bytes)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void wipe_books();
		int p;
		pages_open  = 0;
		bytes_total = '0;
		for (p = 0; p < PAGES; p++) fill[p] = '0;
		for (p = 0; p < TAGS; p++) begin
			tag_count[p] = '0;
			tag_sum[p]   = '0;
		end
	endfunction

	// first-fit placement over the opened pages, else open the next one
	function automatic outcome_t place_request(op_t kind, logic [20:0] size, logic [7:0] tag);
		outcome_t    res;
		logic [20:0] room;
		logic [48:0] sum48;
		logic [32:0] sum32;
		int          slot;
		int          p;
		res  = '0;
		room = (size_setting > PAGE_LIMIT) ? PAGE_LIMIT : size_setting;
		case (kind)
		OP_ALLOC: begin
			if (size == '0) res.st = ST_ZERO;
			else if (size > room) res.st = ST_BIG;
			else begin
				slot = -1;
				for (p = 0; p < pages_open; p++)
					if (slot < 0 && {1'b0, fill[p]} + {1'b0, size} <= {1'b0, room}) slot = p;
				if (slot < 0 && pages_open < PAGES) begin
					slot       = pages_open;
					fill[slot] = '0;
					pages_open++;
				end
				if (slot < 0) res.st = ST_FULL;
				else begin
					res.page   = slot[7:0];
					res.offset = fill[slot][19:0];
					fill[slot] = fill[slot] + size;
					sum48 = {1'b0, bytes_total} + size;
					bytes_total = sum48[48] ? '1 : sum48[47:0];
					sum32 = {1'b0, tag_count[tag]} + 33'd1;
					tag_count[tag] = sum32[32] ? '1 : sum32[31:0];
					sum48 = {1'b0, tag_sum[tag]} + size;
					tag_sum[tag] = sum48[48] ? '1 : sum48[47:0];
				end
			end
		end
		OP_REWIND: for (p = 0; p < PAGES; p++) fill[p] = '0;
		OP_RELEASE: wipe_books();
		default: ;
		endcase
		res.total = bytes_total;
		res.count = tag_count[tag];
		res.bytes = tag_sum[tag];
		return res;
	endfunction

	function automatic row_t mk_row(op_t kind, logic [20:0] size, logic [7:0] tag, bit known,
			status_t st, logic [7:0] page, logic [19:0] off, logic [47:0] total,
			logic [31:0] cnt, logic [47:0] bytes);
		row_t r;
		r.kind = kind;
		r.size = size;
		r.tag  = tag;
		r.known = known;
		r.want.st = st;
		r.want.page = page;
		r.want.offset = off;
		r.want.total = total;
		r.want.count = cnt;
		r.want.bytes = bytes;
		return r;
	endfunction

	function automatic logic [20:0] draw_size(logic [20:0] room);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return '0;
		if (r < 10) return room;
		if (r < 14) return room + 21'd1;
		if (r < 18) return 21'($urandom_range(0, 21'h1FFFFF));
		return 21'($urandom_range(1, (room > 21'd8) ? room / 8 : 1));
	endfunction

	task automatic flag(string what, logic [47:0] got, logic [47:0] want);
		errors++;
		$display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
			what, results_seen, got, want);
	endtask

	task automatic offer(op_t kind, logic [20:0] size, logic [7:0] tag, bit known,
			outcome_t want);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			// sometimes hold back until the block is ready, so the gap lands there
			if ($urandom_range(0, 1) == 1) begin
				do @(posedge clk); while (in_stall);
				@(negedge clk);
			end
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= kind;
		request_size <= size;
		request_tag  <= tag;
		row_known    = known;
		row_want     = want;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	task automatic write_page_bytes(logic [20:0] value);
		cfg_valid  <= 1'b1;
		page_bytes <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// prediction on each accepted request, checking on each accepted result
	always @(posedge clk) begin : watch
		outcome_t predicted;
		outcome_t want;
		if (cfg_valid && cfg_ready) size_setting = page_bytes;
		if (in_valid && !in_stall) begin
			predicted = place_request(op_t'(operation), request_size, request_tag);
			pending_results.push_back(row_known ? row_want : predicted);
			items_taken++;
			outstanding++;
		end
		if (out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) flag("unexpected transaction", 48'd1, 48'd0);
			else begin
				want = pending_results.pop_front();
				outstanding--;
				if (status != want.st) flag("status", 48'(status), 48'(want.st));
				if (page_number != want.page)
					flag("page_number", 48'(page_number), 48'(want.page));
				if (page_offset != want.offset)
					flag("page_offset", 48'(page_offset), 48'(want.offset));
				if (total_bytes != want.total) flag("total_bytes", total_bytes, want.total);
				if (tag_allocations != want.count)
					flag("tag_allocations", 48'(tag_allocations), 48'(want.count));
				if (tag_bytes != want.bytes) flag("tag_bytes", tag_bytes, want.bytes);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("paged_bump_allocator verification failed");
			$finish;
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	initial begin
		hold_off = 1'b0;
		wait (items_taken >= 60);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_OFF) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) out_stall <= 1'b1;
			else if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				out_stall <= 1'b0;
			end else out_stall <= 1'b0;
		end
	end

	initial begin
		int          ph;
		int          n;
		int          k;
		logic [20:0] setting;
		logic [20:0] room;
		op_t         kind;
		logic [7:0]  tg;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_ALLOC;
		request_size = '0;
		request_tag  = '0;
		cfg_valid    = 1'b0;
		page_bytes   = PAGE_BYTES_RESET;
		row_known    = 1'b0;
		row_want     = '0;
		calm         = 1'b0;
		size_setting = PAGE_BYTES_RESET;
		wipe_books();

		// rows typed in were worked out by hand for the reset page size of 4096
		directed[0]  = mk_row(OP_ALLOC, 21'd0, 8'd0, 1'b1,
			ST_ZERO, 8'd0, 20'd0, 48'd0, 32'd0, 48'd0);
		directed[1]  = mk_row(OP_ALLOC, 21'd4097, 8'd255, 1'b1,
			ST_BIG, 8'd0, 20'd0, 48'd0, 32'd0, 48'd0);
		directed[2]  = mk_row(OP_ALLOC, 21'h1FFFFF, 8'd1, 1'b1,
			ST_BIG, 8'd0, 20'd0, 48'd0, 32'd0, 48'd0);
		directed[3]  = mk_row(OP_ALLOC, 21'd1, 8'd255, 1'b1,
			ST_OK, 8'd0, 20'd0, 48'd1, 32'd1, 48'd1);
		directed[4]  = mk_row(OP_ALLOC, 21'd4095, 8'd255, 1'b1,
			ST_OK, 8'd0, 20'd1, 48'd4096, 32'd2, 48'd4096);
		directed[5]  = mk_row(OP_ALLOC, 21'd4096, 8'd0, 1'b1,
			ST_OK, 8'd1, 20'd0, 48'd8192, 32'd1, 48'd4096);
		directed[6]  = mk_row(OP_ALLOC, 21'd100, 8'd7, 1'b1,
			ST_OK, 8'd2, 20'd0, 48'd8292, 32'd1, 48'd100);
		directed[7]  = mk_row(OP_ALLOC, 21'd50, 8'd7, 1'b1,
			ST_OK, 8'd2, 20'd100, 48'd8342, 32'd2, 48'd150);
		directed[8]  = mk_row(OP_REWIND, 21'd0, 8'd7, 1'b1,
			ST_OK, 8'd0, 20'd0, 48'd8342, 32'd2, 48'd150);
		directed[9]  = mk_row(OP_ALLOC, 21'd10, 8'd7, 1'b1,
			ST_OK, 8'd0, 20'd0, 48'd8352, 32'd3, 48'd160);
		directed[10] = mk_row(OP_NONE, 21'd5, 8'd255, 1'b1,
			ST_OK, 8'd0, 20'd0, 48'd8352, 32'd2, 48'd4096);
		directed[11] = mk_row(OP_RELEASE, 21'd0, 8'd7, 1'b1,
			ST_OK, 8'd0, 20'd0, 48'd0, 32'd0, 48'd0);
		directed[12] = mk_row(OP_ALLOC, 21'd4096, 8'd128, 1'b1,
			ST_OK, 8'd0, 20'd0, 48'd4096, 32'd1, 48'd4096);
		directed[13] = mk_row(OP_ALLOC, 21'd1, 8'd128, 1'b1,
			ST_OK, 8'd1, 20'd0, 48'd4097, 32'd2, 48'd4097);
		directed[14] = mk_row(OP_ALLOC, 21'd4095, 8'd64, 1'b1,
			ST_OK, 8'd1, 20'd1, 48'd8192, 32'd1, 48'd4095);
		directed[15] = mk_row(OP_ALLOC, 21'd2000, 8'd3, 1'b0,
			ST_OK, 8'd0, 20'd0, 48'd0, 32'd0, 48'd0);
		directed[16] = mk_row(OP_RELEASE, 21'd0, 8'd0, 1'b1,
			ST_OK, 8'd0, 20'd0, 48'd0, 32'd0, 48'd0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < 17; k++)
			offer(directed[k].kind, directed[k].size, directed[k].tag, directed[k].known,
				directed[k].want);
		row_known = 1'b0;

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			setting = (ph == RANDOM_PAGE_PHASE) ? 21'($urandom_range(1, PAGE_LIMIT))
				: phase_page[ph];
			room    = (setting > PAGE_LIMIT) ? PAGE_LIMIT : setting;
			write_page_bytes(setting);
			if (ph == PHASES - 1) calm = 1'b1;
			for (n = 0; n < phase_items[ph]; n++) begin
				kind = OP_ALLOC;
				if ($urandom_range(0, 99) < phase_ctrl[ph]) begin
					case ($urandom_range(0, 3))
					0, 1: kind = OP_REWIND;
					2: kind = OP_RELEASE;
					default: kind = OP_NONE;
					endcase
				end
				// a few busy tags pile up statistics, the rest spread over all tags
				tg = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
					: 8'($urandom_range(0, 255));
				offer(kind, draw_size(room), tg, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) $display("paged_bump_allocator verification clean");
		else $display("paged_bump_allocator verification failed");
		$finish;
	end

endmodule
